>>> rtl/core/tcp_segmentation_offload_macros.svh
// assertion macros shared by the segmentation offload rtl
`ifndef TCP_SEGMENTATION_OFFLOAD_MACROS_SVH
`define TCP_SEGMENTATION_OFFLOAD_MACROS_SVH

// plain property, sampled on clk_i, off while in reset
`define TSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TSO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tso_pkg.sv
// types, constants and codes of the segmentation offload block
package tso_pkg;

  localparam int MAX_SEGMENTS = 64;

  localparam int MAX_FRAME_W  = 14;
  localparam int GAP_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = MAX_FRAME_W;
  // segment payload limit times segment count must fit the subtractor
  localparam int ALU_W        = MAX_FRAME_W + $clog2(MAX_SEGMENTS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_BYTES = 2'd1;

  localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RST = 14'd1514;
  localparam logic [GAP_W-1:0]       GAP_RST       = 7'd8;

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0]  MASK_NOT_FIRST = 8'h7f;
  localparam logic [7:0]  MASK_NOT_LAST  = 8'hf6;

  typedef enum logic [1:0] {
    KIND_UNCHANGED = 2'd0,
    KIND_SINGLE    = 2'd1,
    KIND_SEGMENT   = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] eth_type;
    logic [7:0]  ip_proto;
    logic [3:0]  ip_hdr_words;
    logic [3:0]  tcp_hdr_words;
    logic [15:0] ip_length_in;
    logic [31:0] seq_in;
    logic [7:0]  flags_in;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  header_len;
    logic [15:0] payload_start;
    logic [15:0] payload_len;
    logic [15:0] ip_length_out;
    logic [31:0] seq_out;
    logic [7:0]  flags_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
    logic             zero;
  } alu_res_t;

endpackage

>>> rtl/core/tcp_segmentation_offload.sv
// segmentation offload top level: sequencer, config registers, output register
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   tso_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i tso_pkg::out_item_t
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one packet at a time; the shared subtractor decides the class in states size,
// pay, mss and cnt, then one segment descriptor leaves per cycle unless stalled
// non-tcp frames skip them, single frames use size and pay, malformed end in
// mss or cnt; reset is asynchronous: sequencer idle, max frame 1514, gap_bytes 8
// out stall holds the output register and pauses the sequencer; a new packet is
// taken while the last result of the previous one still waits
`include "tcp_segmentation_offload_macros.svh"

module tcp_segmentation_offload (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tso_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tso_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tso_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_PAY,
    S_MSS,
    S_CNT,
    S_SEG,
    S_ONE
  } state_e;

  localparam int AW = tso_pkg::ALU_W;

  state_e state_q;

  logic [tso_pkg::MAX_FRAME_W-1:0] max_frame_q;
  logic [tso_pkg::GAP_W-1:0]       gap_q;

  tso_pkg::kind_e kind_q;
  logic [7:0]  held_header_len_q;
  logic [15:0] held_frame_len_q;
  logic [15:0] ip_length_q;
  logic [31:0] running_seq_q;
  logic [7:0]  held_flags_q;
  logic [15:0] pay_q;
  logic [15:0] next_offset_q;
  logic [15:0] rem_q;
  logic [tso_pkg::MAX_FRAME_W-1:0] mss_q;
  logic        fits_q;
  logic        first_q;

  logic                 out_valid_q;
  tso_pkg::out_item_t   out_q;
  tso_pkg::out_item_t   out_d;

  logic [7:0]    hl_in;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  tso_pkg::alu_res_t alu_res;

  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic          seg_last;
  logic [15:0]   seg_len;
  logic [16:0]   gap_sum;
  logic [7:0]    seg_flags;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = out_free && ((state_q == S_SEG) || (state_q == S_ONE));

  assign hl_in = tso_pkg::ETH_HDR_LEN + {2'b00, in_data_i.ip_hdr_words, 2'b00}
               + {2'b00, in_data_i.tcp_hdr_words, 2'b00};

  // operand selection for the shared subtractor
  always_comb begin
    unique case (state_q)
      S_SIZE: begin
        alu_a = AW'(max_frame_q);
        alu_b = AW'(held_frame_len_q);
      end
      S_PAY: begin
        alu_a = AW'(held_frame_len_q);
        alu_b = AW'(held_header_len_q);
      end
      S_MSS: begin
        alu_a = AW'(max_frame_q);
        alu_b = AW'(held_header_len_q);
      end
      S_CNT: begin
        alu_a = AW'(mss_q) * AW'(tso_pkg::MAX_SEGMENTS);
        alu_b = AW'(pay_q);
      end
      S_SEG: begin
        alu_a = AW'(mss_q);
        alu_b = AW'(rem_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  tso_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // rem not above mss closes the packet
  assign seg_last = !alu_res.borrow;
  assign seg_len  = seg_last ? rem_q : 16'(mss_q);
  assign gap_sum  = {1'b0, ip_length_q} + 17'(gap_q);

  always_comb begin
    seg_flags = held_flags_q;
    if (!first_q) begin
      seg_flags = seg_flags & tso_pkg::MASK_NOT_FIRST;
    end
    if (!seg_last) begin
      seg_flags = seg_flags & tso_pkg::MASK_NOT_LAST;
    end
  end

  always_comb begin
    out_d = '0;
    out_d.last = 1'b1;
    if (state_q == S_SEG) begin
      out_d.kind          = tso_pkg::KIND_SEGMENT;
      out_d.header_len    = held_header_len_q;
      out_d.payload_start = next_offset_q;
      out_d.payload_len   = seg_len;
      out_d.ip_length_out = 16'(held_header_len_q - tso_pkg::ETH_HDR_LEN) + seg_len
                          + 16'(gap_q);
      out_d.seq_out       = running_seq_q;
      out_d.flags_out     = seg_flags;
      out_d.last          = seg_last;
    end else begin
      out_d.kind = kind_q;
      unique case (kind_q)
        tso_pkg::KIND_UNCHANGED: begin
          out_d.ip_length_out = ip_length_q;
          out_d.seq_out       = running_seq_q;
          out_d.flags_out     = held_flags_q;
        end
        tso_pkg::KIND_SINGLE: begin
          out_d.header_len    = held_header_len_q;
          out_d.payload_start = 16'(held_header_len_q);
          out_d.payload_len   = pay_q;
          out_d.ip_length_out = gap_sum[16] ? 16'hffff : gap_sum[15:0];
          out_d.seq_out       = running_seq_q;
          out_d.flags_out     = held_flags_q;
        end
        tso_pkg::KIND_SEGMENT, tso_pkg::KIND_MALFORMED: begin
          out_d.header_len = held_header_len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      max_frame_q       <= tso_pkg::MAX_FRAME_RST;
      gap_q             <= tso_pkg::GAP_RST;
      kind_q            <= tso_pkg::KIND_UNCHANGED;
      held_header_len_q <= '0;
      held_frame_len_q  <= '0;
      ip_length_q       <= '0;
      running_seq_q     <= '0;
      held_flags_q      <= '0;
      pay_q             <= '0;
      next_offset_q     <= '0;
      rem_q             <= '0;
      mss_q             <= '0;
      fits_q            <= 1'b0;
      first_q           <= 1'b0;
      out_valid_q       <= 1'b0;
      out_q             <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          tso_pkg::CFG_MAX_FRAME: max_frame_q <= cfg_data_i;
          tso_pkg::CFG_GAP_BYTES: gap_q <= cfg_data_i[tso_pkg::GAP_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            held_header_len_q <= hl_in;
            held_frame_len_q  <= in_data_i.frame_len;
            ip_length_q       <= in_data_i.ip_length_in;
            running_seq_q     <= in_data_i.seq_in;
            held_flags_q      <= in_data_i.flags_in;
            if (in_data_i.eth_type != tso_pkg::ETYPE_IPV4 ||
                in_data_i.ip_proto != tso_pkg::PROTO_TCP) begin
              kind_q  <= tso_pkg::KIND_UNCHANGED;
              state_q <= S_ONE;
            end else begin
              state_q <= S_SIZE;
            end
          end
        end
        S_SIZE: begin
          fits_q  <= !alu_res.borrow;
          state_q <= S_PAY;
        end
        S_PAY: begin
          if (fits_q) begin
            kind_q  <= tso_pkg::KIND_SINGLE;
            pay_q   <= alu_res.borrow ? 16'd0 : alu_res.diff[15:0];
            state_q <= S_ONE;
          end else begin
            pay_q   <= alu_res.diff[15:0];
            state_q <= S_MSS;
          end
        end
        S_MSS: begin
          if (alu_res.borrow || alu_res.zero) begin
            kind_q  <= tso_pkg::KIND_MALFORMED;
            state_q <= S_ONE;
          end else begin
            mss_q   <= alu_res.diff[tso_pkg::MAX_FRAME_W-1:0];
            state_q <= S_CNT;
          end
        end
        S_CNT: begin
          // payload beyond mss times the segment limit
          if (alu_res.borrow) begin
            kind_q  <= tso_pkg::KIND_MALFORMED;
            state_q <= S_ONE;
          end else begin
            kind_q        <= tso_pkg::KIND_SEGMENT;
            next_offset_q <= 16'(held_header_len_q);
            rem_q         <= pay_q;
            first_q       <= 1'b1;
            state_q       <= S_SEG;
          end
        end
        S_SEG: begin
          if (out_free) begin
            next_offset_q <= next_offset_q + seg_len;
            running_seq_q <= running_seq_q + 32'(seg_len);
            rem_q         <= rem_q - seg_len;
            first_q       <= 1'b0;
            if (seg_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  `TSO_ASSERT_IMPL(a_single_last, out_valid_q && out_q.kind != tso_pkg::KIND_SEGMENT,
    out_q.last, "non-segment result without last")
  `TSO_ASSERT_IMPL(a_seg_rem, state_q == S_SEG, rem_q != 16'd0,
    "segmenting with no payload left")
  `TSO_ASSERT_IMPL(a_seg_span, state_q == S_SEG,
    16'(next_offset_q + rem_q) == held_frame_len_q, "segment offset and remainder disagree")
  `TSO_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_q != S_IDLE,
    "sequencer idle right after an input transfer")

endmodule

>>> rtl/core/tso_alu.sv
// shared subtract and compare unit of the segmentation sequencer
module tso_alu (
  input  logic [tso_pkg::ALU_W-1:0] a_i,
  input  logic [tso_pkg::ALU_W-1:0] b_i,
  output tso_pkg::alu_res_t         res_o
);

  logic [tso_pkg::ALU_W:0] full;

  assign full = {1'b0, a_i} - {1'b0, b_i};

  assign res_o.diff   = full[tso_pkg::ALU_W-1:0];
  assign res_o.borrow = full[tso_pkg::ALU_W];
  assign res_o.zero   = (full == '0);

endmodule

>>> tb/tcp_segmentation_offload_checker.sv
// descriptor predictor and scoreboard for the segmentation offload block
module tcp_segmentation_offload_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  tso_pkg::in_item_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  tso_pkg::out_item_t              out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [tso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tso_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [tso_pkg::MAX_FRAME_W-1:0] max_frame_q;
  logic [tso_pkg::GAP_W-1:0]       gap_q;

  // segmenter working registers, kept from the last segmented packet
  logic [15:0] seg_offset;
  logic [31:0] seg_seq;
  logic [7:0]  seg_hdr_len;
  logic [15:0] seg_frame_len;
  logic [7:0]  seg_flags;

  tso_pkg::out_item_t expected_desc_q[$];
  tso_pkg::out_item_t want;
  int        mismatch_cnt = 0;
  int        checked_cnt = 0;
  int        pending_cnt = 0;

  assign errors_o  = mismatch_cnt;
  assign pending_o = pending_cnt;
  assign checked_o = checked_cnt;

  task automatic predict_descriptors(input tso_pkg::in_item_t pkt);
    tso_pkg::out_item_t d;
    int        hdr;
    int        mss;
    int        nseg;
    int        off;
    int        seg_len;
    int        ipl;
    bit        final_seg;
    d = '0;
    d.last = 1'b1;
    if (pkt.eth_type != tso_pkg::ETYPE_IPV4 || pkt.ip_proto != tso_pkg::PROTO_TCP) begin
      d.kind          = tso_pkg::KIND_UNCHANGED;
      d.ip_length_out = pkt.ip_length_in;
      d.seq_out       = pkt.seq_in;
      d.flags_out     = pkt.flags_in;
      expected_desc_q.push_back(d);
      return;
    end
    hdr = int'(tso_pkg::ETH_HDR_LEN) + 4 * int'(pkt.ip_hdr_words)
        + 4 * int'(pkt.tcp_hdr_words);
    d.header_len = 8'(hdr);
    if (pkt.frame_len <= max_frame_q) begin
      ipl = int'(pkt.ip_length_in) + int'(gap_q);
      if (ipl > 65535) ipl = 65535;
      d.kind          = tso_pkg::KIND_SINGLE;
      d.payload_start = 16'(hdr);
      d.payload_len   = (int'(pkt.frame_len) >= hdr) ? 16'(int'(pkt.frame_len) - hdr) : 16'd0;
      d.ip_length_out = 16'(ipl);
      d.seq_out       = pkt.seq_in;
      d.flags_out     = pkt.flags_in;
      expected_desc_q.push_back(d);
      return;
    end
    mss  = int'(max_frame_q) - hdr;
    nseg = (mss > 0) ? (int'(pkt.frame_len) - hdr + mss - 1) / mss : 0;
    // header fills the whole frame limit, or too many segments needed
    if (mss <= 0 || nseg > tso_pkg::MAX_SEGMENTS) begin
      d.kind = tso_pkg::KIND_MALFORMED;
      expected_desc_q.push_back(d);
      return;
    end
    seg_hdr_len   = 8'(hdr);
    seg_frame_len = pkt.frame_len;
    seg_flags     = pkt.flags_in;
    seg_offset    = 16'(hdr);
    seg_seq       = pkt.seq_in;
    for (int k = 0; k < nseg; k++) begin
      off       = int'(seg_offset);
      seg_len   = int'(seg_frame_len) - off;
      if (seg_len > mss) seg_len = mss;
      final_seg = (off + mss >= int'(seg_frame_len));
      d.kind          = tso_pkg::KIND_SEGMENT;
      d.header_len    = seg_hdr_len;
      d.payload_start = 16'(off);
      d.payload_len   = 16'(seg_len);
      d.ip_length_out = 16'(int'(seg_hdr_len) - int'(tso_pkg::ETH_HDR_LEN) + seg_len
                            + int'(gap_q));
      d.seq_out       = seg_seq;
      d.flags_out     = seg_flags;
      if (k != 0) d.flags_out = d.flags_out & tso_pkg::MASK_NOT_FIRST;
      if (!final_seg) d.flags_out = d.flags_out & tso_pkg::MASK_NOT_LAST;
      d.last          = final_seg;
      expected_desc_q.push_back(d);
      seg_seq    = seg_seq + 32'(seg_len);
      seg_offset = 16'(off + seg_len);
    end
  endtask

  function automatic bit desc_match(input tso_pkg::out_item_t e,
                                    input tso_pkg::out_item_t a);
    return e.kind === a.kind && e.header_len === a.header_len
        && e.payload_start === a.payload_start && e.payload_len === a.payload_len
        && e.ip_length_out === a.ip_length_out && e.seq_out === a.seq_out
        && e.flags_out === a.flags_out && e.last === a.last;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q   = tso_pkg::MAX_FRAME_RST;
      gap_q         = tso_pkg::GAP_RST;
      seg_offset    = '0;
      seg_seq       = '0;
      seg_hdr_len   = '0;
      seg_frame_len = '0;
      seg_flags     = '0;
      expected_desc_q.delete();
      pending_cnt   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_cnt++;
        if (expected_desc_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("%t: descriptor with nothing expected: kind %0d hl %0d start %0d",
                     $realtime, out_data_i.kind, out_data_i.header_len,
                     out_data_i.payload_start);
        end else begin
          want = expected_desc_q.pop_front();
          if (!desc_match(want, out_data_i)) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT) begin
              $display("%t: descriptor mismatch", $realtime);
              $display("  expected kind %0d hl %0d start %0d len %0d ipl %0d seq %h fl %h last %b",
                       want.kind, want.header_len, want.payload_start, want.payload_len,
                       want.ip_length_out, want.seq_out, want.flags_out, want.last);
              $display("  actual   kind %0d hl %0d start %0d len %0d ipl %0d seq %h fl %h last %b",
                       out_data_i.kind, out_data_i.header_len, out_data_i.payload_start,
                       out_data_i.payload_len, out_data_i.ip_length_out, out_data_i.seq_out,
                       out_data_i.flags_out, out_data_i.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_descriptors(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tso_pkg::CFG_MAX_FRAME)
          max_frame_q = cfg_data_i[tso_pkg::MAX_FRAME_W-1:0];
        else if (cfg_index_i == tso_pkg::CFG_GAP_BYTES)
          gap_q = cfg_data_i[tso_pkg::GAP_W-1:0];
      end
      pending_cnt = expected_desc_q.size();
    end
  end

endmodule

>>> tb/tcp_segmentation_offload_tb.sv
// stimulus and verdict for the segmentation offload block
module tcp_segmentation_offload_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                            CYCLE_LIMIT    = 400000;
  localparam int                            CHUNK_ITEMS    = 18;
  localparam int                            CHUNKS         = 6;
  localparam logic [tso_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  tso_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  tso_pkg::out_item_t             out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [tso_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [tso_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  int errors;
  int pending;
  int checked;
  int send_idle_pct  = 22;
  int recv_stall_pct = 48;
  int packets_sent   = 0;
  int reg_writes     = 0;
  int cycle_cnt      = 0;
  int cur_max_frame  = 1514;

  tcp_segmentation_offload dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcp_segmentation_offload_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[tcp_segmentation_offload] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic tso_pkg::in_item_t tcp_item(input logic [15:0] flen,
                                                 input logic [3:0] ihl,
                                                 input logic [3:0] doff,
                                                 input logic [15:0] iplen,
                                                 input logic [31:0] seq,
                                                 input logic [7:0] flags);
    tso_pkg::in_item_t p;
    p.frame_len     = flen;
    p.eth_type      = tso_pkg::ETYPE_IPV4;
    p.ip_proto      = tso_pkg::PROTO_TCP;
    p.ip_hdr_words  = ihl;
    p.tcp_hdr_words = doff;
    p.ip_length_in  = iplen;
    p.seq_in        = seq;
    p.flags_in      = flags;
    return p;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_packet(input tso_pkg::in_item_t pkt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = pkt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    packets_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tso_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == tso_pkg::CFG_MAX_FRAME) cur_max_frame = int'(val);
    reg_writes++;
  endtask

  initial begin
    tso_pkg::in_item_t pkt;
    int       r;
    int       s;
    int       hi;
    int       fs;
    int       gap;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: max frame 1514, gap 8
    send_packet(tcp_item(16'd60, 4'd5, 4'd5, 16'd46, 32'h0000_0001, 8'h18));
    pkt = tcp_item(16'd600, 4'd5, 4'd5, 16'd586, 32'hdead_beef, 8'h10);
    pkt.eth_type = 16'h86dd;
    send_packet(pkt);
    pkt.eth_type = tso_pkg::ETYPE_IPV4;
    pkt.ip_proto = 8'd17;
    send_packet(pkt);
    send_packet('1);
    send_packet('0);
    send_packet(tcp_item(16'd20, 4'd15, 4'd15, 16'd65535, 32'hffff_ffff, 8'hff));
    send_packet(tcp_item(16'd1514, 4'd5, 4'd5, 16'd65530, 32'h8000_0000, 8'h09));
    send_packet(tcp_item(16'd0, 4'd0, 4'd0, 16'd0, 32'h0, 8'h00));
    send_packet(tcp_item(16'd1515, 4'd5, 4'd5, 16'd1501, 32'h1234_5678, 8'hff));
    send_packet(tcp_item(16'd65535, 4'd5, 4'd5, 16'd65521, 32'h0bad_f00d, 8'h89));
    send_packet(tcp_item(16'd4000, 4'd5, 4'd8, 16'd3986, 32'hffff_ff00, 8'h09));
    send_packet(tcp_item(16'd3000, 4'd0, 4'd0, 16'd2986, 32'h7fff_ffff, 8'h81));

    // tiny frame limit: header too long, segment count at and above the cap
    wait_all_results();
    write_reg(tso_pkg::CFG_MAX_FRAME, 14'd98);
    write_reg(tso_pkg::CFG_GAP_BYTES, {7'h55, 7'd127});
    write_reg(CFG_UNUSED_IDX, '1);
    send_packet(tcp_item(16'd200, 4'd15, 4'd15, 16'd186, 32'h1, 8'hff));
    send_packet(tcp_item(16'd99, 4'd11, 4'd10, 16'd85, 32'h2, 8'hff));
    send_packet(tcp_item(16'd2870, 4'd5, 4'd5, 16'd2856, 32'hffff_f000, 8'hff));
    send_packet(tcp_item(16'd2871, 4'd5, 4'd5, 16'd2857, 32'h3, 8'hff));
    send_packet(tcp_item(16'd98, 4'd5, 4'd5, 16'd65500, 32'h4, 8'h89));

    wait_all_results();
    write_reg(tso_pkg::CFG_MAX_FRAME, 14'h3fff);
    write_reg(tso_pkg::CFG_GAP_BYTES, {7'h2a, 7'd0});
    send_packet(tcp_item(16'd65535, 4'd0, 4'd0, 16'd65521, 32'hffff_fff0, 8'hff));

    wait_all_results();
    write_reg(tso_pkg::CFG_MAX_FRAME, 14'd1158);
    write_reg(tso_pkg::CFG_GAP_BYTES, {7'h00, 7'd64});
    send_packet(tcp_item(16'd1159, 4'd15, 4'd15, 16'd1145, 32'h5555_aaaa, 8'h89));
    send_packet(tcp_item(16'd65535, 4'd15, 4'd15, 16'd65521, 32'haaaa_5555, 8'hff));

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      wait_all_results();
      if (chunk < 2) begin
        send_idle_pct  = 22;
        recv_stall_pct = 48;
      end else if (chunk < 4) begin
        send_idle_pct  = 48;
        recv_stall_pct = 22;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(0, 5))
        0:       fs = 1158;
        1:       fs = 9018;
        2:       fs = $urandom_range(1158, 9018);
        3:       fs = 1514;
        4:       fs = $urandom_range(60, 400);
        default: fs = $urandom_range(9019, 16383);
      endcase
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = 64;
        2:       gap = 127;
        default: gap = $urandom_range(0, 64);
      endcase
      write_reg(tso_pkg::CFG_MAX_FRAME, 14'(fs));
      write_reg(tso_pkg::CFG_GAP_BYTES, {7'($urandom), 7'(gap)});

      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        // hold the sender off until the block has drained
        if (chunk == 0 && n == CHUNK_ITEMS / 2) wait_all_results();
        r = $urandom_range(0, 99);
        pkt.seq_in        = $urandom;
        pkt.flags_in      = 8'($urandom);
        pkt.ip_length_in  = 16'($urandom);
        pkt.eth_type      = tso_pkg::ETYPE_IPV4;
        pkt.ip_proto      = tso_pkg::PROTO_TCP;
        pkt.ip_hdr_words  = 4'($urandom_range(5, 15));
        pkt.tcp_hdr_words = 4'($urandom_range(5, 15));
        if (r < 75) begin
          if (r < 8) pkt.ip_hdr_words = 4'($urandom_range(0, 4));
          hi = (cur_max_frame * 6 > 65535) ? 65535 : cur_max_frame * 6;
          s  = $urandom_range(0, 99);
          if (s < 40) pkt.frame_len = 16'($urandom_range(0, cur_max_frame));
          else if (s < 88) pkt.frame_len = 16'($urandom_range(cur_max_frame + 1, hi));
          else pkt.frame_len = 16'($urandom_range(cur_max_frame + 1, 65535));
        end else begin
          pkt.frame_len     = 16'($urandom);
          pkt.ip_hdr_words  = 4'($urandom);
          pkt.tcp_hdr_words = 4'($urandom);
          case (r % 3)
            0: begin
              pkt.eth_type = 16'($urandom);
              pkt.ip_proto = 8'($urandom);
            end
            1: begin
              pkt.ip_proto = 8'($urandom);
              if (pkt.ip_proto == tso_pkg::PROTO_TCP) pkt.ip_proto = 8'd17;
            end
            default: pkt.eth_type = 16'($urandom);
          endcase
        end
        send_packet(pkt);
      end
    end

    wait_all_results();
    repeat (16) @(posedge clk_i);
    $display("covered %0d packets and %0d register writes under three pacing modes",
             packets_sent, reg_writes);
    $display("%0d result descriptors compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("[tcp_segmentation_offload] OK");
    end else begin
      $display("[tcp_segmentation_offload] ERROR");
    end
    $finish;
  end

endmodule
